// File: sv/gtpu_pkg.sv
`timescale 1ns / 1ps

package gtpu_pkg;

  localparam int unsigned MAX_HEADER_BYTES = 1023;
  localparam int unsigned HDR_LIMIT = (MAX_HEADER_BYTES < 1023) ? MAX_HEADER_BYTES : 1023;
  localparam logic [11:0] HDR_LIMIT_W = 12'(HDR_LIMIT);
  localparam logic [9:0] OFFSET_MAX = 10'd1023;

  localparam logic [2:0] VERDICT_USER_DATA = 3'd0;
  localparam logic [2:0] VERDICT_ECHO_REQ = 3'd1;
  localparam logic [2:0] VERDICT_BAD_VERSION = 3'd2;
  localparam logic [2:0] VERDICT_OTHER_TYPE = 3'd3;
  localparam logic [2:0] VERDICT_TRUNCATED = 3'd4;
  localparam logic [2:0] VERDICT_ZERO_EXT = 3'd5;
  localparam logic [2:0] VERDICT_TOO_LONG = 3'd6;

  localparam logic [7:0] TYPE_ECHO_REQ = 8'd1;
  localparam logic [7:0] TYPE_TPDU = 8'd255;
  localparam logic [7:0] TYPE_EMARK = 8'd254;
  localparam logic [2:0] GTP_VERSION_1 = 3'd1;
  localparam int unsigned FLAG_S_BIT = 1;

  localparam logic [9:0] HDR_BASE_BYTES = 10'd8;
  localparam logic [9:0] HDR_OPT_BYTES = 10'd12;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } gtpu_in_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [7:0]  message_type;
    logic [31:0] tunnel_id;
    logic [9:0]  header_bytes;
    logic [15:0] sequence_number;
    logic        sequence_present;
  } gtpu_out_t;

  typedef struct packed {
    logic [9:0]  byte_offset;
    logic [7:0]  flags_held;
    logic [7:0]  type_held;
    logic [31:0] teid_held;
    logic [15:0] seq_held;
    logic [9:0]  header_end;
    logic        verdict_given;
  } gtpu_state_t;

  localparam gtpu_state_t STATE_CLEAR = '{
    byte_offset:   10'd0,
    flags_held:    8'd0,
    type_held:     8'd0,
    teid_held:     32'd0,
    seq_held:      16'd0,
    header_end:    HDR_BASE_BYTES,
    verdict_given: 1'b0
  };

endpackage

// File: sv/gtpu_byte_step.sv
`timescale 1ns / 1ps

module gtpu_byte_step (
  input  gtpu_pkg::gtpu_state_t st,
  input  gtpu_pkg::gtpu_in_t    in_item,
  output gtpu_pkg::gtpu_state_t st_nxt,
  output logic                  res_valid,
  output gtpu_pkg::gtpu_out_t   res
);

  logic [9:0]  off;
  logic [7:0]  b;
  logic [11:0] ext_end;
  logic [10:0] off_p1;
  logic        ver_ok;
  logic        any_opt;
  logic        seq_flag;
  logic        sp;
  logic [2:0]  verdict;

  assign off = st.byte_offset;
  assign b = in_item.data_byte;
  assign ext_end = {2'b00, st.header_end} + {2'b00, b, 2'b00};
  assign off_p1 = {1'b0, off} + 11'd1;

  always_comb begin
    st_nxt = st;
    res_valid = 1'b0;
    verdict = gtpu_pkg::VERDICT_USER_DATA;
    res = '0;
    ver_ok = 1'b0;
    any_opt = 1'b0;
    seq_flag = 1'b0;
    sp = 1'b0;
    if (!st.verdict_given) begin
      if (off == 10'd0) begin
        st_nxt.flags_held = b;
      end else if (off == 10'd1) begin
        st_nxt.type_held = b;
      end else if (off >= 10'd4 && off <= 10'd7) begin
        case (off[1:0])
          2'd0: st_nxt.teid_held[31:24] = st.teid_held[31:24] | b;
          2'd1: st_nxt.teid_held[23:16] = st.teid_held[23:16] | b;
          2'd2: st_nxt.teid_held[15:8] = st.teid_held[15:8] | b;
          default: st_nxt.teid_held[7:0] = st.teid_held[7:0] | b;
        endcase
      end else if (off == 10'd8) begin
        st_nxt.seq_held[15:8] = st.seq_held[15:8] | b;
      end else if (off == 10'd9) begin
        st_nxt.seq_held[7:0] = st.seq_held[7:0] | b;
      end

      ver_ok = (st_nxt.flags_held[7:5] == gtpu_pkg::GTP_VERSION_1);
      any_opt = (st_nxt.flags_held[2:0] != 3'd0);
      seq_flag = st_nxt.flags_held[gtpu_pkg::FLAG_S_BIT];

      if (off == 10'd7) begin
        if (!ver_ok) begin
          res_valid = 1'b1;
          verdict = gtpu_pkg::VERDICT_BAD_VERSION;
        end else begin
          if (any_opt) begin
            st_nxt.header_end = gtpu_pkg::HDR_OPT_BYTES;
          end
          if (st_nxt.type_held == gtpu_pkg::TYPE_ECHO_REQ) begin
            if (!seq_flag) begin
              res_valid = 1'b1;
              verdict = gtpu_pkg::VERDICT_ECHO_REQ;
            end
          end else if (st_nxt.type_held != gtpu_pkg::TYPE_TPDU &&
                       st_nxt.type_held != gtpu_pkg::TYPE_EMARK) begin
            res_valid = 1'b1;
            verdict = gtpu_pkg::VERDICT_OTHER_TYPE;
          end else if (!any_opt) begin
            res_valid = 1'b1;
            verdict = gtpu_pkg::VERDICT_USER_DATA;
          end
        end
      end else if (off > 10'd7) begin
        if (st.type_held == gtpu_pkg::TYPE_ECHO_REQ) begin
          if (off == 10'd9) begin
            res_valid = 1'b1;
            verdict = gtpu_pkg::VERDICT_ECHO_REQ;
          end
        end else if (off_p1 == {1'b0, st.header_end}) begin
          if (b == 8'd0) begin
            res_valid = 1'b1;
            verdict = gtpu_pkg::VERDICT_USER_DATA;
          end
        end else if (off == st.header_end) begin
          if (b == 8'd0) begin
            res_valid = 1'b1;
            verdict = gtpu_pkg::VERDICT_ZERO_EXT;
          end else if (ext_end > gtpu_pkg::HDR_LIMIT_W) begin
            res_valid = 1'b1;
            verdict = gtpu_pkg::VERDICT_TOO_LONG;
          end else begin
            st_nxt.header_end = ext_end[9:0];
          end
        end
      end

      if (!res_valid && in_item.last_byte) begin
        res_valid = 1'b1;
        verdict = gtpu_pkg::VERDICT_TRUNCATED;
      end

      sp = (verdict != gtpu_pkg::VERDICT_BAD_VERSION) && ver_ok && seq_flag;
      res.verdict = verdict;
      res.message_type = st_nxt.type_held;
      res.tunnel_id = st_nxt.teid_held;
      res.header_bytes = st_nxt.header_end;
      res.sequence_number = sp ? st_nxt.seq_held : 16'd0;
      res.sequence_present = sp;
      if (res_valid) begin
        st_nxt.verdict_given = 1'b1;
      end
      st_nxt.byte_offset = (off < gtpu_pkg::OFFSET_MAX) ? off_p1[9:0] : gtpu_pkg::OFFSET_MAX;
    end
    if (in_item.last_byte) begin
      st_nxt = gtpu_pkg::STATE_CLEAR;
    end
  end

endmodule

// File: sv/gtpu_header_parser.sv
`timescale 1ns / 1ps

// GTP-U v1 header parser. Takes the packet byte by byte, flags octet first, and
// returns at most one verdict per packet, in the cycle after its deciding byte;
// remaining bytes up to last_byte are absorbed without a result. Throughput is
// one byte every cycle while in_ready is high: the per-byte decode is a single
// pass of compare and add logic between the packet state register and the
// result register, which frees in_ready whenever out_ready is high.

module gtpu_header_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gtpu_pkg::gtpu_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gtpu_pkg::gtpu_out_t out_data
);

  gtpu_pkg::gtpu_state_t state_r;
  gtpu_pkg::gtpu_state_t state_nxt;
  gtpu_pkg::gtpu_out_t   res;
  gtpu_pkg::gtpu_out_t   out_data_r;
  gtpu_pkg::gtpu_out_t   out_data_nxt;
  logic                  res_valid;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  accept;

  gtpu_byte_step u_step (
    .st        (state_r),
    .in_item   (in_data),
    .st_nxt    (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    if (accept) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_data_nxt = res;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gtpu_pkg::STATE_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  a_hdr_end_floor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.header_end >= gtpu_pkg::HDR_BASE_BYTES)
    else $error("header end below base header");

  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.verdict <= gtpu_pkg::VERDICT_TOO_LONG)
    else $error("verdict code out of range");

  a_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.sequence_present |-> out_data_r.sequence_number == 16'd0)
    else $error("sequence number without S flag");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.last_byte |=> state_r.byte_offset == 10'd0 && !state_r.verdict_given)
    else $error("packet state not cleared after last item");

  a_one_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    accept && state_r.verdict_given |=> !out_valid_r)
    else $error("second verdict in one packet");

endmodule
